@@ design/pkht_pkg.sv @@
// ----------------------------------------------------------------------------
// pkht_pkg
// Shared types, constants and helpers of the pair key hash table.
// ----------------------------------------------------------------------------
package pkht_pkg;

   // number of slots; a power of two, so the home slot is the low hash bits
   localparam int TABLE_SIZE = 1024;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);

   localparam int ID_W     = 32;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 10;
   localparam int HALF_W   = 32;

   localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
   localparam int MIX_S0 = 30;
   localparam int MIX_S1 = 27;
   localparam int MIX_S2 = 31;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EQUAL_IDS = 3'd5;

   typedef struct packed {
      logic               command;
      logic [ID_W-1:0]    source_id;
      logic [ID_W-1:0]    dest_id;
      logic [VALUE_W-1:0] insert_value;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  slot_index;
      logic [VALUE_W-1:0]  found_value;
   } rsp_item_type;

   // partial product of the 64-bit multiply, low 64 bits only
   typedef enum logic [1:0] {
      MUL_LL,
      MUL_LH,
      MUL_HL
   } mul_sel_type;

   typedef struct packed {
      logic                load;
      mul_sel_type         mul_sel;
      logic                round;
      logic                acc_load;
      logic                acc_add;
      logic                mix_load;
      logic                pos_load;
      logic                probe_next;
      logic                mem_read;
      logic                mem_write;
      logic                clear_step;
      logic                result_load;
      logic [STATUS_W-1:0] result_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic equal_ids;
      logic is_lookup;
      logic slot_valid;
      logic key_match;
      logic last_probe;
      logic clear_done;
   } dp_status_type;

   function automatic logic [INDEX_W-1:0] slot_index_of(input logic [SLOT_W-1:0] pos);
      logic [SLOT_W+INDEX_W-1:0] wide;
      wide = {{INDEX_W{1'b0}}, pos};
      return wide[INDEX_W-1:0];
   endfunction

endpackage

@@ design/pkht_ctrl.sv @@
// ----------------------------------------------------------------------------
// pkht_ctrl
// Sequencer: table clear after reset, two-round hash multiply, probe loop
// and result handoff to the output register.
// ----------------------------------------------------------------------------
module pkht_ctrl import pkht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EQUAL,
      S_MUL_LL,
      S_MUL_LH,
      S_MUL_HL,
      S_MUL_END,
      S_READ,
      S_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      round_ff, round_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_LL;
      cmd.round    = round_ff;
      state_in     = state_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               round_in = 1'b0;
               state_in = S_MUL_LL;
            end
         end
         S_EQUAL: begin
            if (out_free) begin
               cmd.result_load   = 1'b1;
               cmd.result_status = ST_EQUAL_IDS;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_MUL_LL: begin
            cmd.mul_sel = MUL_LL;
            priority if (status.equal_ids && !status.is_lookup) begin
               state_in = S_EQUAL;
            end else begin
               state_in = S_MUL_LH;
            end
         end
         S_MUL_LH: begin
            cmd.mul_sel  = MUL_LH;
            cmd.acc_load = 1'b1;
            state_in     = S_MUL_HL;
         end
         S_MUL_HL: begin
            cmd.mul_sel = MUL_HL;
            cmd.acc_add = 1'b1;
            state_in    = S_MUL_END;
         end
         S_MUL_END: begin
            priority if (!round_ff) begin
               cmd.mix_load = 1'b1;
               round_in     = 1'b1;
               state_in     = S_MUL_LL;
            end else begin
               cmd.pos_load = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            priority if (!status.slot_valid) begin
               if (out_free) begin
                  cmd.result_load   = 1'b1;
                  cmd.mem_write     = !status.is_lookup;
                  cmd.result_status = status.is_lookup ? ST_NOT_FOUND : ST_INSERTED;
                  rsp_valid_in      = 1'b1;
                  state_in          = S_IDLE;
               end
            end else if (status.key_match) begin
               if (out_free) begin
                  cmd.result_load   = 1'b1;
                  cmd.result_status = status.is_lookup ? ST_FOUND : ST_PRESENT;
                  rsp_valid_in      = 1'b1;
                  state_in          = S_IDLE;
               end
            end else if (status.last_probe) begin
               if (out_free) begin
                  cmd.result_load   = 1'b1;
                  cmd.result_status = status.is_lookup ? ST_NOT_FOUND : ST_FULL;
                  rsp_valid_in      = 1'b1;
                  state_in          = S_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         round_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/pkht_dp.sv @@
// ----------------------------------------------------------------------------
// pkht_dp
// Datapath: item capture, shared 32x32 multiplier for the mix function,
// probe address and counter, slot memories and the output register.
// ----------------------------------------------------------------------------
module pkht_dp import pkht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  req_item,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output rsp_item_type  rsp_item
);

   // slot entry: valid flag above the key
   logic [KEY_W:0]        entry_mem [TABLE_SIZE];
   logic [VALUE_W-1:0]    value_mem [TABLE_SIZE];

   logic                  command_ff;
   logic                  equal_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic [KEY_W-1:0]      x_ff;
   logic [KEY_W-1:0]      prod_ff, prod_in;
   logic [KEY_W-1:0]      acc_ff;
   logic [SLOT_W-1:0]     pos_ff;
   logic [SLOT_W-1:0]     probe_ff;
   logic [SLOT_W-1:0]     clr_addr_ff;
   logic [KEY_W:0]        rd_entry_ff;
   logic [VALUE_W-1:0]    rd_value_ff;
   rsp_item_type          rsp_item_ff;

   logic [KEY_W-1:0]      key_in;
   logic [KEY_W-1:0]      sum;
   logic [KEY_W-1:0]      hash;
   logic [KEY_W-1:0]      mul_const;
   logic [HALF_W-1:0]     mul_a, mul_b;
   logic [SLOT_W-1:0]     wr_addr;
   logic [KEY_W:0]        wr_entry;
   logic                  wr_en;

   assign key_in    = {req_item.source_id, req_item.dest_id};
   assign mul_const = cmd.round ? MIX_C2 : MIX_C1;
   assign mul_a     = (cmd.mul_sel == MUL_HL) ? x_ff[KEY_W-1:HALF_W] : x_ff[HALF_W-1:0];
   assign mul_b     = (cmd.mul_sel == MUL_LH) ? mul_const[KEY_W-1:HALF_W]
                                               : mul_const[HALF_W-1:0];
   assign prod_in   = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   assign sum       = {acc_ff[KEY_W-1:HALF_W] + prod_ff[HALF_W-1:0], acc_ff[HALF_W-1:0]};
   assign hash      = sum ^ (sum >> MIX_S2);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         command_ff <= req_item.command;
         equal_ff   <= (req_item.source_id == req_item.dest_id);
         key_ff     <= key_in;
         value_ff   <= req_item.insert_value;
         x_ff       <= key_in ^ (key_in >> MIX_S0);
      end else if (cmd.mix_load) begin
         x_ff <= sum ^ (sum >> MIX_S1);
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= sum;
      end
      if (cmd.pos_load) begin
         pos_ff   <= hash[SLOT_W-1:0];
         probe_ff <= '0;
      end else if (cmd.probe_next) begin
         pos_ff   <= pos_ff + 1'b1;
         probe_ff <= probe_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign wr_en    = cmd.clear_step || cmd.mem_write;
   assign wr_addr  = cmd.clear_step ? clr_addr_ff : pos_ff;
   assign wr_entry = cmd.clear_step ? '0 : {1'b1, key_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      if (cmd.mem_write) begin
         value_mem[pos_ff] <= value_ff;
      end
      if (cmd.mem_read) begin
         rd_entry_ff <= entry_mem[pos_ff];
         rd_value_ff <= value_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_item_ff.status      <= cmd.result_status;
         rsp_item_ff.slot_index  <= (cmd.result_status == ST_PRESENT) ?
                                    slot_index_of(pos_ff) : '0;
         rsp_item_ff.found_value <= (cmd.result_status == ST_FOUND) ? rd_value_ff : '0;
      end
   end

   assign rsp_item = rsp_item_ff;

   assign status.equal_ids  = equal_ff;
   assign status.is_lookup  = (command_ff == CMD_LOOKUP);
   assign status.slot_valid = rd_entry_ff[KEY_W];
   assign status.key_match  = (rd_entry_ff[KEY_W-1:0] == key_ff);
   assign status.last_probe = (probe_ff == SLOT_W'(TABLE_SIZE - 1));
   assign status.clear_done = (clr_addr_ff == SLOT_W'(TABLE_SIZE - 1));

endmodule

@@ design/pair_key_hash_table.sv @@
// ----------------------------------------------------------------------------
// pair_key_hash_table
// Open-addressing hash table keyed by an ordered pair of 32-bit vertex ids,
// splitmix64 home slot, linear probing, insert-if-absent and lookup.
// ----------------------------------------------------------------------------
//   channel  ports                       payload
//   request  req_valid / req_stall       req_item  (req_item_type)
//   result   rsp_valid / rsp_stall       rsp_item  (rsp_item_type)
//
// An item passes an accept state, the hash (two 64-bit multiplies, each three
// 32x32 partial products on one shared multiplier: MUL_LL, MUL_LH, MUL_HL,
// MUL_END) and READ and CHECK per probe of the slot memory; an equal-id insert
// ends after MUL_LL. After reset the slot memory is cleared one entry a cycle,
// all TABLE_SIZE entries, with req_stall high. One item is in work at a time;
// a new item is taken while the previous result still waits under rsp_stall.
// ----------------------------------------------------------------------------
module pair_key_hash_table import pkht_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pkht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pkht_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
